/* sv/connection_admission_limiter_defines.svh */
// ----------------------------------------------------------------------------
// Connection admission limiter assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_ADMISSION_LIMITER_DEFINES_SVH
`define CONNECTION_ADMISSION_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on clk and silent while reset is held.
`define CAL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and silent while reset is held.
`define CAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cal_pkg.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter package
// Types and constants shared by the front end, queue and engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

	localparam int ADDR_W  = 32;
	localparam int STAMP_W = 48;
	localparam int CNT_W   = 16;
	localparam int TMO_W   = 32;

	typedef enum logic [2:0] {
		OP_ADMIT   = 3'd0,
		OP_PROMOTE = 3'd1,
		OP_RELEASE = 3'd2,
		OP_SWEEP   = 3'd3,
		OP_QUERY   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_PER_ADDRESS_LIMIT = 2'd0,
		CFG_GLOBAL_LIMIT      = 2'd1,
		CFG_HALF_OPEN_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  addr;
		logic [STAMP_W-1:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] per_address_limit;
		logic [CNT_W-1:0] global_limit;
		logic [TMO_W-1:0] half_open_timeout;
	} cfg_t;

	typedef struct packed {
		logic               used;
		logic [ADDR_W-1:0]  key;
		logic [CNT_W-1:0]   embryonic;
		logic [CNT_W-1:0]   established;
		logic [STAMP_W-1:0] oldest;
	} row_t;

	typedef struct packed {
		logic             admitted;
		logic [CNT_W-1:0] reaped_count;
		logic [CNT_W-1:0] address_inflight;
		logic [CNT_W-1:0] global_inflight;
	} result_t;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

`default_nettype wire

/* sv/connection_admission_limiter.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter
// Per-address and global connection limits over a fixed address table.
// ----------------------------------------------------------------------------
// Usage: each input item carries an opcode (admit, promote, release, sweep,
// query), a source address and the current time in milliseconds, and is
// accepted when in_valid and in_ready are both high. Every item yields exactly
// one result item on the out channel, in order, under the same handshake.
// Opcodes 5 to 7 behave as query.
// Operation: the engine walks the whole table for every item, one entry per
// cycle through the single read port of the table memory, and starts a new
// item only once the last result has moved to the output register. One item
// is in the engine at a time; three more can wait in the command queue and
// the front stage.
// Reset: all counts and totals clear, the registers return to 8, 1024 and
// 5000, and a clearing pass then empties the table. No item is accepted
// during that pass; configuration writes are taken as usual.
// Stall: when the receiver holds out_ready low, the result stays in the output
// register, the engine finishes its next item and waits, and the queue then
// fills before in_ready falls. The user is to write configuration while idle
// only; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_admission_limiter import cal_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         opcode,
	input  wire logic [ADDR_W-1:0]  peer_address,
	input  wire logic [STAMP_W-1:0] time_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    admitted,
	output logic [CNT_W-1:0]        reaped_count,
	output logic [CNT_W-1:0]        address_inflight,
	output logic [CNT_W-1:0]        global_inflight,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [TMO_W-1:0]   cfg_data
);

	// Configuration registers, written directly by index.
	cfg_t    cfg_q;
	logic    clearing;
	logic    push_valid, push_ready;
	cmd_t    push_cmd;
	logic    pop_valid, pop_ready;
	cmd_t    pop_cmd;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.per_address_limit <= 16'd8;
			cfg_q.global_limit      <= 16'd1024;
			cfg_q.half_open_timeout <= 32'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PER_ADDRESS_LIMIT: cfg_q.per_address_limit <= cfg_data[CNT_W-1:0];
				CFG_GLOBAL_LIMIT:      cfg_q.global_limit      <= cfg_data[CNT_W-1:0];
				CFG_HALF_OPEN_TIMEOUT: cfg_q.half_open_timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front stage is held off while the table is being cleared.
	cal_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.enable       (!clearing),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.peer_address (peer_address),
		.time_ms      (time_ms),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	cal_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	cal_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clearing  (clearing),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign admitted         = res.admitted;
	assign reaped_count     = res.reaped_count;
	assign address_inflight = res.address_inflight;
	assign global_inflight  = res.global_inflight;

endmodule

`default_nettype wire

/* sv/cal_front.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter front end
// Accepts items, folds unused opcodes into query and feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_front import cal_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               enable,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         opcode,
	input  wire logic [ADDR_W-1:0]  peer_address,
	input  wire logic [STAMP_W-1:0] time_ms,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output cmd_t                    push_cmd
);

	logic valid_s1;
	cmd_t cmd_s1;
	op_t  op_class;

	always_comb begin
		case (opcode)
			OP_ADMIT:   op_class = OP_ADMIT;
			OP_PROMOTE: op_class = OP_PROMOTE;
			OP_RELEASE: op_class = OP_RELEASE;
			OP_SWEEP:   op_class = OP_SWEEP;
			default:    op_class = OP_QUERY;
		endcase
	end

	assign in_ready   = enable && (!valid_s1 || push_ready);
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.op     <= op_class;
			cmd_s1.addr   <= peer_address;
			cmd_s1.now_ms <= time_ms;
		end
	end

endmodule

`default_nettype wire

/* sv/cal_queue.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter command queue
// Two-entry queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_queue import cal_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	cmd_t       slots_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

/* sv/cal_engine.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter engine
// Scans the address table, applies one command and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_engine import cal_pkg::*; #(
	parameter int ENTRIES = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	output logic      clearing,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  wire cmd_t pop_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   out_res
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W:0]   SCAN_END = (IDX_W+1)'(ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	row_t mem [ENTRIES];

	state_t state_q, state_d;

	logic [IDX_W-1:0] clr_idx_q;
	logic [IDX_W:0]   scan_cnt_q;
	logic             chk_v_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	row_t             rd_row_s1;

	cmd_t             cmd_q;
	logic             found_q;
	logic [IDX_W-1:0] fidx_q;
	row_t             frow_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [CNT_W-1:0] tho_q;
	logic [CNT_W-1:0] test_q;
	logic [CNT_W-1:0] reaped_q;
	result_t          res_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             issuing;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	row_t             mem_wdata;

	logic                 is_match;
	logic                 is_free;
	logic [STAMP_W-1:0]   age;
	logic                 stale_hit;
	logic [CNT_W:0]       reaped_sum;
	logic [CNT_W-1:0]     tho_swept;

	logic [CNT_W-1:0] cur_ho, cur_est;
	logic [CNT_W:0]   tot_sum, slot_sum;
	logic [CNT_W-1:0] new_ho, new_est, new_tho, new_test;
	logic             ex_adm, ex_wr, ex_have_slot;
	logic [IDX_W-1:0] ex_tgt;
	row_t             ex_row;
	result_t          ex_res;

	assign clearing  = (state_q == ST_CLEAR);
	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	assign issuing = (state_q == ST_SCAN) && (scan_cnt_q < SCAN_END);
	assign rd_addr = scan_cnt_q[IDX_W-1:0];

	// Per-row checks on the row that the memory returned this cycle.
	assign is_match  = rd_row_s1.used && (rd_row_s1.key == cmd_q.addr);
	assign is_free   = !rd_row_s1.used ||
		(rd_row_s1.embryonic == '0 && rd_row_s1.established == '0);
	assign age       = cmd_q.now_ms - rd_row_s1.oldest;
	assign stale_hit = chk_v_s1 && (cmd_q.op == OP_SWEEP) && rd_row_s1.used &&
		(rd_row_s1.embryonic != '0) && (age > {16'd0, cfg.half_open_timeout});
	assign reaped_sum = {1'b0, reaped_q} + {1'b0, rd_row_s1.embryonic};
	assign tho_swept  = (rd_row_s1.embryonic > tho_q) ? '0 : tho_q - rd_row_s1.embryonic;

	// Apply the command to the row found by the scan.
	always_comb begin
		cur_ho       = found_q ? frow_q.embryonic : '0;
		cur_est      = found_q ? frow_q.established : '0;
		tot_sum      = {1'b0, tho_q} + {1'b0, test_q};
		slot_sum     = {1'b0, cur_ho} + {1'b0, cur_est};
		new_ho       = cur_ho;
		new_est      = cur_est;
		new_tho      = tho_q;
		new_test     = test_q;
		ex_adm       = 1'b0;
		ex_wr        = 1'b0;
		ex_have_slot = found_q || free_q;
		ex_tgt       = found_q ? fidx_q : free_idx_q;
		ex_row       = frow_q;
		case (cmd_q.op)
			OP_ADMIT: begin
				if (tot_sum < {1'b0, cfg.global_limit} && ex_have_slot &&
					slot_sum < {1'b0, cfg.per_address_limit}) begin
					ex_adm  = 1'b1;
					ex_wr   = 1'b1;
					new_ho  = cur_ho + 1'b1;
					new_tho = tho_q + 1'b1;
				end
			end
			OP_PROMOTE: begin
				if (found_q && cur_ho != '0) begin
					ex_wr    = 1'b1;
					new_ho   = cur_ho - 1'b1;
					new_est  = cur_est + 1'b1;
					new_tho  = (tho_q == '0) ? '0 : tho_q - 1'b1;
					new_test = test_q + 1'b1;
				end
			end
			OP_RELEASE: begin
				if (found_q && cur_est != '0) begin
					ex_wr    = 1'b1;
					new_est  = cur_est - 1'b1;
					new_test = (test_q == '0) ? '0 : test_q - 1'b1;
				end else if (found_q && cur_ho != '0) begin
					ex_wr   = 1'b1;
					new_ho  = cur_ho - 1'b1;
					new_tho = (tho_q == '0) ? '0 : tho_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		ex_row.used        = 1'b1;
		ex_row.key         = cmd_q.addr;
		ex_row.embryonic   = new_ho;
		ex_row.established = new_est;
		if (cur_ho == '0) begin
			ex_row.oldest = cmd_q.now_ms;
		end
		ex_res.admitted         = ex_adm;
		ex_res.reaped_count     = (cmd_q.op == OP_SWEEP) ? reaped_q : '0;
		ex_res.address_inflight = ((cmd_q.op != OP_SWEEP) && (found_q || ex_adm)) ?
			new_ho + new_est : '0;
		ex_res.global_inflight  = new_tho + new_test;
	end

	// Next state and memory write port.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stale_hit) begin
					mem_we              = 1'b1;
					mem_waddr           = chk_idx_s1;
					mem_wdata           = rd_row_s1;
					mem_wdata.embryonic = '0;
				end
				if (!issuing && !chk_v_s1) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				mem_we    = ex_wr;
				mem_waddr = ex_tgt;
				mem_wdata = ex_row;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_row_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			scan_cnt_q  <= '0;
			chk_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			tho_q       <= '0;
			test_q      <= '0;
			reaped_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			chk_v_s1 <= issuing;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (issuing) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (state_q == ST_IDLE && pop_valid) begin
				scan_cnt_q <= '0;
				found_q    <= 1'b0;
				free_q     <= 1'b0;
				reaped_q   <= '0;
			end
			if (state_q == ST_SCAN && chk_v_s1 && cmd_q.op != OP_SWEEP) begin
				if (is_match && !found_q) begin
					found_q <= 1'b1;
				end
				if (is_free && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (stale_hit) begin
				tho_q    <= tho_swept;
				reaped_q <= reaped_sum[CNT_W] ? CNT_MAX : reaped_sum[CNT_W-1:0];
			end
			if (state_q == ST_EXEC) begin
				tho_q  <= new_tho;
				test_q <= new_test;
			end
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			cmd_q <= pop_cmd;
		end
		if (state_q == ST_SCAN && chk_v_s1 && is_match && !found_q) begin
			fidx_q <= chk_idx_s1;
			frow_q <= rd_row_s1;
		end
		if (state_q == ST_SCAN && chk_v_s1 && is_free && !free_q) begin
			free_idx_q <= chk_idx_s1;
		end
		chk_idx_s1 <= rd_addr;
		if (state_q == ST_EXEC) begin
			res_q <= ex_res;
		end
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

endmodule

`default_nettype wire

/* sv/cal_checker.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "connection_admission_limiter_defines.svh"

module cal_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        admitted,
	input wire logic [15:0] reaped_count,
	input wire logic [15:0] address_inflight,
	input wire logic [15:0] global_inflight
);

	// A stalled result keeps its contents.
	`CAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(admitted) && $stable(reaped_count) && $stable(address_inflight) && $stable(global_inflight), "result changed while stalled")

	// An accepted admit is never a sweep and always leaves the address counted.
	`CAL_ASSERT_SAME(a_admit_no_reap, out_valid && admitted, reaped_count == 16'd0, "admit reported reaped connections")
	`CAL_ASSERT_SAME(a_admit_counted, out_valid && admitted, address_inflight != 16'd0, "admit left address with no connections")

	// Only a sweep reaps, and a sweep reports no address.
	`CAL_ASSERT_SAME(a_reap_no_addr, out_valid && reaped_count != 16'd0, address_inflight == 16'd0 && !admitted, "sweep reported an address count")

endmodule

bind connection_admission_limiter cal_checker u_cal_checker (.*);

`default_nettype wire

/* test/connection_admission_limiter_tb.sv */
// ----------------------------------------------------------------------------
// Connection admission limiter testbench
// Drives admit, promote, release, sweep and query items through the block,
// predicts each result from a private copy of the address table, and compares
// every result item field by field under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

import cal_pkg::*;

// Scoreboard: holds the predicted table and the queue of expected results.
class limiter_scoreboard;
	localparam int SLOTS = 64;

	logic [CNT_W-1:0]   per_addr_max;
	logic [CNT_W-1:0]   total_max;
	logic [TMO_W-1:0]   stale_after;
	logic               used [SLOTS];
	logic [ADDR_W-1:0]  key [SLOTS];
	logic [CNT_W-1:0]   embryonic [SLOTS];
	logic [CNT_W-1:0]   established [SLOTS];
	logic [STAMP_W-1:0] oldest [SLOTS];
	logic [CNT_W-1:0]   sum_half_open;
	logic [CNT_W-1:0]   sum_established;
	result_t            pending [$];
	int                 errors;

	function new();
		per_addr_max = 16'd8;
		total_max = 16'd1024;
		stale_after = 32'd5000;
		for (int i = 0; i < SLOTS; i++) begin
			used[i] = 1'b0;
			key[i] = '0;
			embryonic[i] = '0;
			established[i] = '0;
			oldest[i] = '0;
		end
		sum_half_open = '0;
		sum_established = '0;
		errors = 0;
	endfunction

	function void set_register(cfg_idx_t idx, logic [TMO_W-1:0] value);
		case (idx)
			CFG_PER_ADDRESS_LIMIT: per_addr_max = value[CNT_W-1:0];
			CFG_GLOBAL_LIMIT:      total_max = value[CNT_W-1:0];
			CFG_HALF_OPEN_TIMEOUT: stale_after = value;
			default: ;
		endcase
	endfunction

	function int lookup(logic [ADDR_W-1:0] addr);
		for (int i = 0; i < SLOTS; i++)
			if (used[i] && key[i] == addr) return i;
		return -1;
	endfunction

	function int vacant();
		for (int i = 0; i < SLOTS; i++)
			if (!used[i] || (embryonic[i] == 0 && established[i] == 0)) return i;
		return -1;
	endfunction

	// Note an accepted input item and queue the result it must produce.
	function void note_input(logic [2:0] op, logic [ADDR_W-1:0] addr,
			logic [STAMP_W-1:0] now);
		result_t r;
		int s;
		int t;
		logic [16:0] reaped;
		logic [STAMP_W-1:0] age;
		r = '0;
		reaped = '0;
		if (op == OP_SWEEP) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!used[i] || embryonic[i] == 0) continue;
				age = now - oldest[i];
				if (age > {16'd0, stale_after}) begin
					sum_half_open = (embryonic[i] > sum_half_open) ? '0 :
						sum_half_open - embryonic[i];
					reaped = reaped + embryonic[i];
					if (reaped > 17'hFFFF) reaped = 17'hFFFF;
					embryonic[i] = '0;
				end
			end
		end else begin
			s = lookup(addr);
			if (op == OP_ADMIT) begin
				if ({1'b0, sum_half_open} + sum_established < {1'b0, total_max}) begin
					t = (s >= 0) ? s : vacant();
					if (t >= 0 && {1'b0, embryonic[t]} + established[t] <
							{1'b0, per_addr_max}) begin
						if (s < 0) begin
							key[t] = addr;
							used[t] = 1'b1;
							embryonic[t] = '0;
							established[t] = '0;
						end
						if (embryonic[t] == 0) oldest[t] = now;
						embryonic[t]++;
						sum_half_open++;
						r.admitted = 1'b1;
						s = t;
					end
				end
			end else if (op == OP_PROMOTE) begin
				if (s >= 0 && embryonic[s] > 0) begin
					embryonic[s]--;
					established[s]++;
					if (sum_half_open > 0) sum_half_open--;
					sum_established++;
				end
			end else if (op == OP_RELEASE) begin
				if (s >= 0) begin
					if (established[s] > 0) begin
						established[s]--;
						if (sum_established > 0) sum_established--;
					end else if (embryonic[s] > 0) begin
						embryonic[s]--;
						if (sum_half_open > 0) sum_half_open--;
					end
				end
			end
			if (s >= 0) r.address_inflight = embryonic[s] + established[s];
		end
		r.reaped_count = reaped[CNT_W-1:0];
		r.global_inflight = sum_half_open + sum_established;
		pending.push_back(r);
	endfunction

	// Compare one result item with the oldest expectation.
	function void check_result(result_t got);
		result_t want;
		if (pending.size() == 0) begin
			$display("%0t: result with nothing expected: %p", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.admitted !== want.admitted) begin
			$display("%0t: admitted expected %0d actual %0d", $time,
				want.admitted, got.admitted);
			errors++;
		end
		if (got.reaped_count !== want.reaped_count) begin
			$display("%0t: reaped_count expected %0d actual %0d", $time,
				want.reaped_count, got.reaped_count);
			errors++;
		end
		if (got.address_inflight !== want.address_inflight) begin
			$display("%0t: address_inflight expected %0d actual %0d", $time,
				want.address_inflight, got.address_inflight);
			errors++;
		end
		if (got.global_inflight !== want.global_inflight) begin
			$display("%0t: global_inflight expected %0d actual %0d", $time,
				want.global_inflight, got.global_inflight);
			errors++;
		end
	endfunction
endclass

module connection_admission_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         opcode = '0;
	logic [ADDR_W-1:0]  peer_address = '0;
	logic [STAMP_W-1:0] time_ms = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               admitted;
	logic [CNT_W-1:0]   reaped_count;
	logic [CNT_W-1:0]   address_inflight;
	logic [CNT_W-1:0]   global_inflight;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [TMO_W-1:0]   cfg_data = '0;

	// Idling odds in percent for each side; the hold-off flag freezes the
	// receiver outright.
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  recv_hold = 1'b0;

	// Monotonic clock of the traffic, plus a small pool of addresses so that
	// lookups hit often and the table can be filled.
	logic [STAMP_W-1:0] clock_ms = '0;
	logic [ADDR_W-1:0]  addr_pool [8];

	limiter_scoreboard book = new();

	always #5 clk = ~clk;

	connection_admission_limiter dut (.*);

	// Receiver: out_ready is redrawn every cycle unless a hold-off is active.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_result('{admitted, reaped_count, address_inflight,
				global_inflight});
		out_ready <= !recv_hold && ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// Offer one item and hold it until it is taken. Valid stays high after
	// acceptance so that the next item can follow at once; stop_sending drops
	// it at the end of a burst.
	task automatic send_item(logic [2:0] op, logic [ADDR_W-1:0] addr,
			logic [STAMP_W-1:0] now);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		peer_address <= addr;
		time_ms <= now;
		do @(posedge clk); while (!in_ready);
		book.note_input(op, addr, now);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	// Wait until every expected result has arrived, plus the engine latency.
	task automatic drain();
		while (book.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_register(cfg_idx_t idx, logic [TMO_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		book.set_register(idx, value);
		@(posedge clk);
	endtask

	// Random item: mostly admit, promote and release on the pool, some sweep,
	// query, unused opcodes and fully random addresses.
	task automatic random_item();
		int pick;
		logic [2:0] op;
		logic [ADDR_W-1:0] addr;
		pick = $urandom_range(99, 0);
		if (pick < 40) op = OP_ADMIT;
		else if (pick < 60) op = OP_PROMOTE;
		else if (pick < 78) op = OP_RELEASE;
		else if (pick < 88) op = OP_SWEEP;
		else if (pick < 95) op = OP_QUERY;
		else op = 3'($urandom_range(7, 5));
		addr = ($urandom_range(9, 0) == 0) ? $urandom() : addr_pool[$urandom_range(7, 0)];
		clock_ms = clock_ms + $urandom_range(1500, 0);
		send_item(op, addr, clock_ms);
	endtask

	task automatic random_phase(int count, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (count) random_item();
		stop_sending();
		drain();
	endtask

	initial begin
		int held;
		for (int i = 0; i < 8; i++) addr_pool[i] = $urandom();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset registers.
		send_item(OP_QUERY, 32'h0, 48'h0);
		send_item(OP_PROMOTE, 32'hFFFF_FFFF, 48'h0);
		send_item(OP_RELEASE, 32'hFFFF_FFFF, 48'h0);
		send_item(OP_ADMIT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF0);
		send_item(OP_ADMIT, 32'h0, 48'hFFFF_FFFF_FFF0);
		send_item(OP_PROMOTE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF1);
		send_item(OP_RELEASE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF2);
		send_item(OP_RELEASE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFF2);
		// Age across the 48-bit wrap: exactly the timeout is not stale.
		send_item(OP_SWEEP, 32'h1234_5678, 48'd5000 - 48'd16);
		send_item(OP_SWEEP, 32'h1234_5678, 48'd5000 - 48'd15);
		send_item(3'd5, 32'h0, 48'd0);
		send_item(3'd6, 32'h0, 48'd0);
		send_item(3'd7, 32'hAAAA_5555, 48'h5555_AAAA_5555);
		// Per-address limit of eight reached, then refused.
		repeat (9) send_item(OP_ADMIT, 32'h5555_AAAA, 48'd100);
		stop_sending();
		drain();

		// Table full: fill every free slot with a new address, then three more.
		write_register(CFG_PER_ADDRESS_LIMIT, 32'd1);
		write_register(CFG_GLOBAL_LIMIT, 32'd65535);
		write_register(CFG_HALF_OPEN_TIMEOUT, 32'hFFFF_FFFF);
		for (int i = 0; i < 66; i++) send_item(OP_ADMIT, 32'h0A00_0000 + i, 48'd200);
		send_item(OP_SWEEP, 32'd0, 48'd0);
		stop_sending();
		drain();
		write_register(CFG_HALF_OPEN_TIMEOUT, 32'd1);
		send_item(OP_SWEEP, 32'd0, 48'd400);
		stop_sending();
		drain();

		// Random phases across register settings and idling mixes.
		write_register(CFG_PER_ADDRESS_LIMIT, 32'd65535);
		write_register(CFG_GLOBAL_LIMIT, 32'd1);
		write_register(CFG_HALF_OPEN_TIMEOUT, 32'd2000);
		random_phase(100, 0, 0);
		write_register(CFG_PER_ADDRESS_LIMIT, 32'd3);
		write_register(CFG_GLOBAL_LIMIT, 32'd20);
		random_phase(200, 48, 0);
		write_register(CFG_PER_ADDRESS_LIMIT, 32'd8);
		write_register(CFG_GLOBAL_LIMIT, 32'd1024);
		write_register(CFG_HALF_OPEN_TIMEOUT, 32'd5000);
		random_phase(200, 0, 48);
		write_register(CFG_GLOBAL_LIMIT, 32'd65535);
		write_register(CFG_HALF_OPEN_TIMEOUT, 32'd300);
		random_phase(200, 6, 6);

		// Long receiver hold-off while the sender keeps offering items, so
		// the queue fills and in_ready falls.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b1;
		fork
			begin
				held = 0;
				while (held < 600) begin
					@(posedge clk);
					held++;
				end
				recv_hold = 1'b0;
			end
			begin
				repeat (10) random_item();
				stop_sending();
			end
		join
		drain();
		random_phase(150, 10, 20);

		if (book.errors == 0 && book.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Timeout guard well beyond the slowest correct run.
	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire
